// ===== src/ladq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the linear array deque.
package ladq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int WORD_W     = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_REAR  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_REAR_FULL = 2'd1,
    ST_NO_ROOM   = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [IDX_W-1:0]      addr;
    logic [DATA_WIDTH-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic             done;
    logic             pop_ok;
    status_t          status;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

// ===== src/ladq_ram.sv =====
`timescale 1ns / 1ps
// Single-port synchronous RAM with registered read data.
module ladq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== src/ladq_ctrl.sv =====
`timescale 1ns / 1ps
// Index bookkeeping, command decode and result register of the deque.
module ladq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [ladq_pkg::CMD_W-1:0]  command,
  input  logic [ladq_pkg::DATA_WIDTH-1:0] push_data,
  output ladq_pkg::mem_req_t          mem_req,
  output ladq_pkg::result_t           result
);
  import ladq_pkg::*;

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic             empty, empty_next;
  status_t          status_c;
  logic             pop_ok_c;
  logic [CNT_W-1:0] count_c;
  cmd_t             cmd;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  assign cmd = cmd_t'(command);

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    empty_next    = empty;
    status_c      = ST_OK;
    pop_ok_c      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = head;
    mem_req.wdata = push_data;
    unique case (cmd)
      CMD_PUSH_REAR: begin
        if (empty) begin
          head_next    = '0;
          tail_next    = '0;
          empty_next   = 1'b0;
          mem_req.addr = '0;
          mem_req.we   = accept;
        end else if (tail == LAST) begin
          status_c = ST_REAR_FULL;
        end else begin
          tail_next    = tail + 1'b1;
          mem_req.addr = tail + 1'b1;
          mem_req.we   = accept;
        end
      end
      CMD_PUSH_FRONT: begin
        if (empty || head == '0) begin
          status_c = ST_NO_ROOM;
        end else begin
          head_next    = head - 1'b1;
          mem_req.addr = head - 1'b1;
          mem_req.we   = accept;
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        mem_req.addr = (cmd == CMD_POP_FRONT) ? head : tail;
        if (empty) begin
          status_c = ST_UNDERFLOW;
        end else begin
          pop_ok_c   = 1'b1;
          mem_req.re = accept;
          if (head == tail) begin
            empty_next = 1'b1;
            head_next  = '0;
            tail_next  = '0;
          end else if (cmd == CMD_POP_FRONT) begin
            head_next = head + 1'b1;
          end else begin
            tail_next = tail - 1'b1;
          end
        end
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  always_comb begin
    if (empty_next) begin
      count_c = '0;
    end else begin
      count_c = CNT_W'({1'b0, tail_next} - {1'b0, head_next} + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      empty       <= 1'b1;
      result.done <= 1'b0;
    end else begin
      result.done <= accept;
      if (accept) begin
        head  <= head_next;
        tail  <= tail_next;
        empty <= empty_next;
      end
    end
    if (accept) begin
      result.pop_ok <= pop_ok_c;
      result.status <= status_c;
      result.count  <= count_c;
    end
  end

endmodule

// ===== src/linear_array_deque.sv =====
`timescale 1ns / 1ps
// Top level of the linear (non-wrapping) array deque.
//
// One command is taken in every cycle: busy stays low, and the result of a
// command appears in the cycle after start, marked by done for exactly that
// cycle; the receiver cannot stall it. The result register and the registered
// read of the slot memory lie between; a push writes its slot at its own accept
// edge, so a pop right behind it reads that slot with no forwarding. Slots
// hold no reset value; only slots filled by a push are ever read.
module linear_array_deque (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [ladq_pkg::CMD_W-1:0]          command,
  input  logic signed [ladq_pkg::WORD_W-1:0]  push_value,
  output logic                                done,
  output logic [ladq_pkg::STAT_W-1:0]         status,
  output logic signed [ladq_pkg::WORD_W-1:0]  popped_value,
  output logic [ladq_pkg::CNT_W-1:0]          element_count
);
  import ladq_pkg::*;

  logic                  accept;
  mem_req_t              mem_req;
  result_t               result;
  logic [DATA_WIDTH-1:0] rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ladq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (command),
    .push_data (DATA_WIDTH'(push_value)),
    .mem_req   (mem_req),
    .result    (result)
  );

  ladq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .re    (mem_req.re),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rdata)
  );

  assign done          = result.done;
  assign status        = result.status;
  assign element_count = result.count;
  assign popped_value  = result.pop_ok ? $signed(WORD_W'(rdata)) : '0;

endmodule

// ===== src/ladq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the linear array deque, bound to the top level.
module ladq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic [ladq_pkg::CMD_W-1:0]          command,
  input logic signed [ladq_pkg::WORD_W-1:0]  push_value,
  input logic                                done,
  input logic [ladq_pkg::STAT_W-1:0]         status,
  input logic signed [ladq_pkg::WORD_W-1:0]  popped_value,
  input logic [ladq_pkg::CNT_W-1:0]          element_count
);
  import ladq_pkg::*;

  a_word_answered: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("accepted command produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without a command");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> popped_value == '0)
    else $error("refused command returned data");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> element_count <= CNT_W'(DEPTH))
    else $error("element count beyond depth");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_UNDERFLOW |-> element_count == '0)
    else $error("underflow reported on a nonempty deque");

endmodule

bind linear_array_deque ladq_checker u_ladq_checker (.*);
